### rtl/core/v4alu_pkg.sv
// Shared types, operation codes and saturation helper for the vec4 arithmetic unit.
package v4alu_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned FRAC_BITS_DEF = 16;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [63:0]       prod_t;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MUL       = 4'd2,
        OP_DIV       = 4'd3,
        OP_SUM       = 4'd4,
        OP_LENGTH    = 4'd5,
        OP_LENSQ     = 4'd6,
        OP_NORMALIZE = 4'd7,
        OP_CROSS     = 4'd8,
        OP_SCALE     = 4'd9,
        OP_DIVSCALAR = 4'd10
    } op_t;

    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;
    localparam logic signed [66:0] SAT_HI = 67'sd2147483647;
    localparam logic signed [66:0] SAT_LO = -67'sd2147483648;

    // entry register
    typedef struct packed {
        op_t         op;
        word_t [3:0] a;
        word_t [3:0] b;
        word_t       s;
    } req_t;

    // after the multiplier bank
    typedef struct packed {
        op_t         op;
        prod_t [3:0] p;
        prod_t [2:0] q;
        word_t [3:0] n;
        word_t [3:0] d;
        logic  [3:0] act;
        word_t [3:0] vr;
        word_t       sc;
    } mul_t;

    // after product reduction
    typedef struct packed {
        op_t         op;
        logic [63:0] h0;
        logic [63:0] h1;
        word_t [3:0] n;
        word_t [3:0] d;
        logic  [3:0] act;
        word_t [3:0] vr;
        word_t       sc;
    } sumsq_t;

    // square root pipeline
    typedef struct packed {
        op_t         op;
        logic [65:0] rad;
        logic [35:0] rem;
        logic [32:0] root;
        word_t [3:0] n;
        word_t [3:0] d;
        logic  [3:0] act;
        word_t [3:0] vr;
        word_t       sc;
    } root_t;

    // one divider lane
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] lo;
        logic [31:0] quo;
        logic [32:0] dmag;
        logic        ovf;
        logic        nneg;
        logic        nzero;
        logic        qneg;
        logic        dzero;
        logic        act;
    } lane_div_t;

    typedef struct packed {
        op_t             op;
        lane_div_t [3:0] ln;
        word_t     [3:0] vr;
        word_t           sc;
        logic            fault;
    } div_t;

    function automatic word_t sat67(input logic signed [66:0] v);
        word_t res;
        if (v > SAT_HI)
        begin
            res = WORD_MAX;
        end
        else if (v < SAT_LO)
        begin
            res = WORD_MIN;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### rtl/core/vec4_arithmetic_unit.sv
// Top level of the four-lane Q16.16 vector arithmetic pipeline.
//
// Fully pipelined vector unit: one request per clock unless the output
// stalls. Most of the pipe consists of the two bit-serial units laid out
// as pipeline stages: a 33-stage integer square root (length and
// normalize) followed by four 32-stage restoring dividers (divide, divide by
// scalar, normalize). Every operation travels the full length, so results
// leave in request order. Stage 1 holds the multiplier bank (seven 32x32),
// stage 2 product shift/saturate and cross differences, stage 3 the sum of
// squares. A stall on the output freezes the whole pipe; in_stall follows
// out_valid & out_stall. Products round toward minus infinity, quotients
// truncate toward zero, all results saturate to 32 bits; a zero divisor or
// zero length raises divide_fault.
module vec4_arithmetic_unit #(
    parameter int unsigned FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [3:0]       operation,
    input  v4alu_pkg::word_t a_x,
    input  v4alu_pkg::word_t a_y,
    input  v4alu_pkg::word_t a_z,
    input  v4alu_pkg::word_t a_w,
    input  v4alu_pkg::word_t b_x,
    input  v4alu_pkg::word_t b_y,
    input  v4alu_pkg::word_t b_z,
    input  v4alu_pkg::word_t b_w,
    input  v4alu_pkg::word_t scale_factor,
    output logic             out_valid,
    input  logic             out_stall,
    output v4alu_pkg::word_t r_x,
    output v4alu_pkg::word_t r_y,
    output v4alu_pkg::word_t r_z,
    output v4alu_pkg::word_t r_w,
    output v4alu_pkg::word_t scalar_out,
    output logic             divide_fault
);
    import v4alu_pkg::*;

    localparam int unsigned SQ_STEPS  = 33;
    localparam int unsigned DIV_STEPS = 32;
    localparam logic [31:0] ONE_FX    = 32'd1 << FRAC_BITS;

    logic adv;

    logic                 req_v_reg, mul_v_reg, sum_v_reg, out_v_reg;
    logic [SQ_STEPS:0]    sq_v_reg;
    logic [DIV_STEPS:0]   div_v_reg;

    req_t   req_reg,  req_next;
    mul_t   mul_reg,  mul_next;
    sumsq_t sum_reg,  sum_next;
    root_t  sq_reg    [0:SQ_STEPS];
    root_t  sq0_next;
    root_t  sq_next   [0:SQ_STEPS-1];
    div_t   div_reg   [0:DIV_STEPS];
    div_t   div0_next;
    div_t   div_next  [0:DIV_STEPS-1];

    word_t [3:0] r_reg, r_next;
    word_t       sc_reg, sc_next;
    logic        fault_reg, fault_next;

    // global advance: the pipe moves unless the held result is stalled
    assign adv      = !(out_v_reg && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        req_next.op   = op_t'(operation);
        req_next.a[0] = a_x;
        req_next.a[1] = a_y;
        req_next.a[2] = a_z;
        req_next.a[3] = a_w;
        req_next.b[0] = b_x;
        req_next.b[1] = b_y;
        req_next.b[2] = b_z;
        req_next.b[3] = b_w;
        req_next.s    = scale_factor;
    end

    // stage 1: operand select, multipliers, add/sub/sum
    word_t av [4];
    word_t bv [4];
    word_t ma [4];
    word_t mb [4];
    word_t qa [3];
    word_t qb [3];

    always_comb
    begin
        mul_next     = '0;
        mul_next.op  = req_reg.op;
        for (int i = 0; i < 4; i++)
        begin
            av[i] = req_reg.a[i];
            bv[i] = req_reg.b[i];
            ma[i] = '0;
            mb[i] = '0;
            mul_next.n[i] = req_reg.a[i];
            mul_next.d[i] = req_reg.b[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            qa[i] = '0;
            qb[i] = '0;
        end
        unique case (req_reg.op)
            OP_ADD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mul_next.vr[i] = sat67(67'(av[i]) + 67'(bv[i]));
                end
            end
            OP_SUB:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mul_next.vr[i] = sat67(67'(av[i]) - 67'(bv[i]));
                end
            end
            OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ma[i] = av[i];
                    mb[i] = bv[i];
                end
            end
            OP_DIV:
            begin
                mul_next.act = 4'hF;
            end
            OP_SUM:
            begin
                mul_next.sc = sat67(67'(av[0]) + 67'(av[1]) + 67'(av[2]) + 67'(av[3]));
            end
            OP_LENGTH, OP_LENSQ:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ma[i] = av[i];
                    mb[i] = av[i];
                end
            end
            OP_NORMALIZE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    ma[i] = av[i];
                    mb[i] = av[i];
                end
                mul_next.act = 4'hF;
            end
            OP_CROSS:
            begin
                ma[0] = av[1]; mb[0] = bv[2];
                ma[1] = av[2]; mb[1] = bv[0];
                ma[2] = av[0]; mb[2] = bv[1];
                qa[0] = av[2]; qb[0] = bv[1];
                qa[1] = av[0]; qb[1] = bv[2];
                qa[2] = av[1]; qb[2] = bv[0];
                mul_next.vr[3] = ONE_FX;
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma[i] = bv[i];
                    mb[i] = req_reg.s;
                end
                mul_next.vr[3] = av[3];
            end
            OP_DIVSCALAR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_next.n[i] = bv[i];
                    mul_next.d[i] = req_reg.s;
                end
                mul_next.act   = 4'h7;
                mul_next.vr[3] = av[3];
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            mul_next.p[i] = 64'(ma[i]) * 64'(mb[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            mul_next.q[i] = 64'(qa[i]) * 64'(qb[i]);
        end
    end

    // stage 2: product shift and saturate, cross differences, square pairs
    prod_t pv [4];
    prod_t qv [3];

    always_comb
    begin
        sum_next.op  = mul_reg.op;
        sum_next.n   = mul_reg.n;
        sum_next.d   = mul_reg.d;
        sum_next.act = mul_reg.act;
        sum_next.sc  = mul_reg.sc;
        for (int i = 0; i < 4; i++)
        begin
            pv[i] = mul_reg.p[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            qv[i] = mul_reg.q[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            sum_next.vr[i] = mul_reg.vr[i];
            unique case (mul_reg.op)
                OP_MUL:
                begin
                    sum_next.vr[i] = sat67(67'(pv[i]) >>> FRAC_BITS);
                end
                OP_SCALE:
                begin
                    if (i < 3)
                    begin
                        sum_next.vr[i] = sat67(67'(pv[i]) >>> FRAC_BITS);
                    end
                end
                OP_CROSS:
                begin
                    if (i < 3)
                    begin
                        sum_next.vr[i] = sat67((67'(pv[i]) - 67'(qv[i])) >>> FRAC_BITS);
                    end
                end
                default:
                begin
                end
            endcase
        end
        // squares are never negative, so each pair fits 64 unsigned bits
        sum_next.h0 = $unsigned(pv[0]) + $unsigned(pv[1]);
        sum_next.h1 = $unsigned(pv[2]) + $unsigned(pv[3]);
    end

    // stage 3: full sum of squares, squared length
    logic [64:0] ssq;

    always_comb
    begin
        ssq           = {1'b0, sum_reg.h0} + {1'b0, sum_reg.h1};
        sq0_next.op   = sum_reg.op;
        sq0_next.rad  = {1'b0, ssq};
        sq0_next.rem  = '0;
        sq0_next.root = '0;
        sq0_next.n    = sum_reg.n;
        sq0_next.d    = sum_reg.d;
        sq0_next.act  = sum_reg.act;
        sq0_next.vr   = sum_reg.vr;
        sq0_next.sc   = sum_reg.sc;
        if (sum_reg.op == OP_LENSQ)
        begin
            sq0_next.sc = sat67($signed({2'b00, ssq}) >>> FRAC_BITS);
        end
    end

    // square root: one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [35:0] rem_t;
        logic [35:0] trial;

        always_comb
        begin
            rem_t          = {sq_reg[k].rem[33:0], sq_reg[k].rad[65:64]};
            trial          = {1'b0, sq_reg[k].root, 2'b01};
            sq_next[k]     = sq_reg[k];
            sq_next[k].rad = {sq_reg[k].rad[63:0], 2'b00};
            if (rem_t >= trial)
            begin
                sq_next[k].rem  = rem_t - trial;
                sq_next[k].root = {sq_reg[k].root[31:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = rem_t;
                sq_next[k].root = {sq_reg[k].root[31:0], 1'b0};
            end
        end
    end

    // divider load: magnitudes, signs, numerator split
    root_t       sq_last;
    logic [31:0] nmag [4];
    logic [31:0] dabs [4];
    word_t       nw   [4];
    word_t       dw   [4];

    always_comb
    begin
        sq_last         = sq_reg[SQ_STEPS];
        div0_next.op    = sq_last.op;
        div0_next.vr    = sq_last.vr;
        div0_next.sc    = sq_last.sc;
        div0_next.fault = 1'b0;
        if (sq_last.op == OP_LENGTH)
        begin
            div0_next.sc = sat67($signed({34'd0, sq_last.root}));
        end
        for (int i = 0; i < 4; i++)
        begin
            nw[i]   = sq_last.n[i];
            dw[i]   = sq_last.d[i];
            nmag[i] = nw[i][31] ? (~nw[i] + 32'd1) : nw[i];
            dabs[i] = dw[i][31] ? (~dw[i] + 32'd1) : dw[i];
            div0_next.ln[i].nneg  = nw[i][31];
            div0_next.ln[i].nzero = (nw[i] == '0);
            if (sq_last.op == OP_NORMALIZE)
            begin
                div0_next.ln[i].dmag = sq_last.root;
                div0_next.ln[i].qneg = nw[i][31];
            end
            else
            begin
                div0_next.ln[i].dmag = {1'b0, dabs[i]};
                div0_next.ln[i].qneg = nw[i][31] ^ dw[i][31];
            end
            div0_next.ln[i].dzero = (div0_next.ln[i].dmag == '0);
            div0_next.ln[i].act   = sq_last.act[i];
            div0_next.ln[i].rem   = 34'(nmag[i] >> (32 - FRAC_BITS));
            div0_next.ln[i].lo    = nmag[i] << FRAC_BITS;
            div0_next.ln[i].quo   = '0;
            div0_next.ln[i].ovf   = 1'b0;
            div0_next.fault = div0_next.fault
                              | (div0_next.ln[i].act & div0_next.ln[i].dzero);
        end
    end

    // restoring division: one quotient bit per stage, four lanes
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [33:0] rt [4];
        logic [33:0] dd [4];

        always_comb
        begin
            div_next[k] = div_reg[k];
            for (int i = 0; i < 4; i++)
            begin
                rt[i] = {div_reg[k].ln[i].rem[32:0], div_reg[k].ln[i].lo[31]};
                dd[i] = {1'b0, div_reg[k].ln[i].dmag};
                div_next[k].ln[i].lo = {div_reg[k].ln[i].lo[30:0], 1'b0};
                if (k == 0)
                begin
                    // quotient needs more than 32 bits
                    div_next[k].ln[i].ovf = (div_reg[k].ln[i].rem >= dd[i]);
                end
                if (rt[i] >= dd[i])
                begin
                    div_next[k].ln[i].rem = rt[i] - dd[i];
                    div_next[k].ln[i].quo = {div_reg[k].ln[i].quo[30:0], 1'b1};
                end
                else
                begin
                    div_next[k].ln[i].rem = rt[i];
                    div_next[k].ln[i].quo = {div_reg[k].ln[i].quo[30:0], 1'b0};
                end
            end
        end
    end

    // result select: sign, saturation, zero divisor
    div_t      dl;
    lane_div_t ld [4];

    always_comb
    begin
        dl         = div_reg[DIV_STEPS];
        sc_next    = dl.sc;
        fault_next = dl.fault;
        for (int i = 0; i < 4; i++)
        begin
            ld[i]     = dl.ln[i];
            r_next[i] = dl.vr[i];
            if (ld[i].act)
            begin
                if (ld[i].dzero)
                begin
                    if (ld[i].nneg)
                    begin
                        r_next[i] = WORD_MIN;
                    end
                    else if (ld[i].nzero)
                    begin
                        r_next[i] = '0;
                    end
                    else
                    begin
                        r_next[i] = WORD_MAX;
                    end
                end
                else if (ld[i].qneg)
                begin
                    if (ld[i].ovf || (ld[i].quo[31] && (ld[i].quo[30:0] != '0)))
                    begin
                        r_next[i] = WORD_MIN;
                    end
                    else
                    begin
                        r_next[i] = ~ld[i].quo + 32'd1;
                    end
                end
                else
                begin
                    if (ld[i].ovf || ld[i].quo[31])
                    begin
                        r_next[i] = WORD_MAX;
                    end
                    else
                    begin
                        r_next[i] = ld[i].quo;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg <= 1'b0;
            mul_v_reg <= 1'b0;
            sum_v_reg <= 1'b0;
            sq_v_reg  <= '0;
            div_v_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            req_v_reg <= in_valid;
            mul_v_reg <= req_v_reg;
            sum_v_reg <= mul_v_reg;
            sq_v_reg  <= {sq_v_reg[SQ_STEPS-1:0], sum_v_reg};
            div_v_reg <= {div_v_reg[DIV_STEPS-1:0], sq_v_reg[SQ_STEPS]};
            out_v_reg <= div_v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_reg    <= req_next;
            mul_reg    <= mul_next;
            sum_reg    <= sum_next;
            sq_reg[0]  <= sq0_next;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                sq_reg[k+1] <= sq_next[k];
            end
            div_reg[0] <= div0_next;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                div_reg[k+1] <= div_next[k];
            end
            r_reg     <= r_next;
            sc_reg    <= sc_next;
            fault_reg <= fault_next;
        end
    end

    assign out_valid    = out_v_reg;
    assign r_x          = r_reg[0];
    assign r_y          = r_reg[1];
    assign r_z          = r_reg[2];
    assign r_w          = r_reg[3];
    assign scalar_out   = sc_reg;
    assign divide_fault = fault_reg;

endmodule
